// ----- rtl/mahs_pkg.sv -----
// ----------------------------------------------------------------------------
// mahs_pkg
// shared types, constants and lookup tables of the mpeg audio header scanner
// ----------------------------------------------------------------------------
package mahs_pkg;

  localparam int PosWidth = 32;  // byte position counter, wraps
  localparam int DvdW     = 35;  // divider dividend width (file length times 8)
  localparam int DvsW     = 20;  // divider divisor width (kbps times 1000)
  localparam int FsW      = 12;  // true frame size width
  localparam int PrdW     = 26;  // 144000 * 448 fits here

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] SyncMin  = 8'hE0;
  localparam logic [3:0] RateBad  = 4'd15;
  localparam logic [3:0] RateFree = 4'd0;
  localparam logic [1:0] SrBad    = 2'd3;

  localparam logic [1:0] VerMpeg1 = 2'd3;
  localparam logic [1:0] VerRsv   = 2'd1;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFree = 2'd1;
  localparam logic [1:0] StRsv  = 2'd2;

  localparam logic [1:0] CfgFileLength = 2'd0;
  localparam logic [1:0] CfgAudioBytes = 2'd1;

  localparam logic [17:0] MulMpeg1 = 18'd144000;
  localparam logic [17:0] MulMpeg2 = 18'd72000;
  localparam logic [9:0]  KbpsToBps = 10'd1000;
  localparam logic [10:0] FrameMax  = 11'd2047;

  localparam logic [8:0] KbpsTab [0:4][0:14] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd288,
      9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128,
      9'd160, 9'd192, 9'd224, 9'd256, 9'd320},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144,
      9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
  };

  localparam logic [15:0] RateTab [0:3][0:2] = '{
    '{16'd11025, 16'd12000, 16'd8000},
    '{16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000},
    '{16'd44100, 16'd48000, 16'd32000}
  };

  typedef enum logic [1:0] {
    SelFs  = 2'd0,
    SelFc  = 2'd1,
    SelDur = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     take_byte;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_fs;
    logic     cap_fc;
    logic     cap_dur;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic need_calc;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/mpeg_audio_header_scanner.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_header_scanner
// finds the first mpeg audio frame header in a byte stream and reports it
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  input   | in_valid_i / in_stall_o   | data_byte_i, restart_i
//  result  | out_valid_o / out_stall_i | status_o .. duration_s_o
//  config  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  one byte per cycle while searching or after a header was reported
//  a header with a decodable size runs frame size, frame count and duration
//    through one shared 35-step restoring divider
//  free rate and reserved version headers skip the divider on the way to the result reg
//  reset clears config, window, position and the found flag
//  a held result blocks the input only once the next header waits for the
//    result register; otherwise only the division sequence and the Done step do
module mpeg_audio_header_scanner import mahs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] header_offset_o,
  output logic [1:0]  version_code_o,
  output logic [1:0]  layer_number_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic        padding_bit_o,
  output logic [1:0]  channel_mode_o,
  output logic [10:0] frame_bytes_o,
  output logic [31:0] frame_count_o,
  output logic [22:0] duration_s_o
);

  cmd_t cmd;  // sequencer to datapath
  sts_t sts;  // datapath to sequencer

  // sequencer: byte intake, division order, result handoff
  mahs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: window, decode tables, multiplier, divider, result registers
  mahs_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .data_byte_i      (data_byte_i),
    .restart_i        (restart_i),
    .status_o         (status_o),
    .header_offset_o  (header_offset_o),
    .version_code_o   (version_code_o),
    .layer_number_o   (layer_number_o),
    .bitrate_kbps_o   (bitrate_kbps_o),
    .sample_rate_hz_o (sample_rate_hz_o),
    .padding_bit_o    (padding_bit_o),
    .channel_mode_o   (channel_mode_o),
    .frame_bytes_o    (frame_bytes_o),
    .frame_count_o    (frame_count_o),
    .duration_s_o     (duration_s_o)
  );

endmodule

// ----- rtl/mahs_div.sv -----
// ----------------------------------------------------------------------------
// mahs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mahs_div import mahs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int CntW = $clog2(DvdW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[DvdW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (trial[DvsW]) begin
        rem_q <= shifted[DvsW-1:0];
        quo_q <= {quo_q[DvdW-2:0], 1'b0};
      end else begin
        rem_q <= trial[DvsW-1:0];
        quo_q <= {quo_q[DvdW-2:0], 1'b1};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/mahs_datapath.sv -----
// ----------------------------------------------------------------------------
// mahs_datapath
// byte window, header decode, config registers, size math and result registers
// ----------------------------------------------------------------------------
module mahs_datapath import mahs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic [7:0]    data_byte_i,
  input  logic          restart_i,
  output logic [1:0]    status_o,
  output logic [31:0]   header_offset_o,
  output logic [1:0]    version_code_o,
  output logic [1:0]    layer_number_o,
  output logic [8:0]    bitrate_kbps_o,
  output logic [15:0]   sample_rate_hz_o,
  output logic          padding_bit_o,
  output logic [1:0]    channel_mode_o,
  output logic [10:0]   frame_bytes_o,
  output logic [31:0]   frame_count_o,
  output logic [22:0]   duration_s_o
);

  // config registers
  logic [31:0] file_len_q, audio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
      audio_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFileLength) file_len_q <= cfg_data_i;
      if (cfg_idx_i == CfgAudioBytes) audio_q <= cfg_data_i;
    end
  end

  // search state, restart clears it before the byte is taken
  logic [23:0]         win_q, win_e;
  logic [1:0]          fill_q, fill_e;
  logic [PosWidth-1:0] pos_q, pos_e, sync_pos;
  logic                found_q, found_e;

  assign win_e   = restart_i ? '0 : win_q;
  assign fill_e  = restart_i ? '0 : fill_q;
  assign pos_e   = restart_i ? '0 : pos_q;
  assign found_e = restart_i ? 1'b0 : found_q;

  // decode of the window plus the incoming byte
  logic [7:0] b0, b1, b2;
  logic [1:0] ver, lbits, layer, sr, chan, status;
  logic [3:0] ridx;
  logic [2:0] row;
  logic [8:0] kbps;
  logic [15:0] hz;
  logic       pad, hdr_ok;

  always_comb begin
    b0    = win_e[23:16];
    b1    = win_e[15:8];
    b2    = win_e[7:0];
    ver   = b1[4:3];
    lbits = b1[2:1];
    layer = 2'(3'd4 - {1'b0, lbits});
    ridx  = b2[7:4];
    sr    = b2[3:2];
    pad   = b2[1];
    chan  = data_byte_i[7:6];
    hdr_ok = (fill_e == 2'd3) && !found_e && (b0 == SyncByte) && (b1 >= SyncMin) &&
             (ridx != RateBad) && (lbits != 2'd0) && (sr != SrBad);
    if (ver == VerMpeg1) row = {1'b0, layer} - 3'd1;
    else if (layer == 2'd1) row = 3'd3;
    else row = 3'd4;
    kbps = KbpsTab[row][ridx];
    hz   = (sr == SrBad) ? 16'd0 : RateTab[ver][sr];
    if (ridx == RateFree) begin
      status = StFree;
      kbps   = '0;
    end else if (ver == VerRsv) begin
      status = StRsv;
      kbps   = '0;
      hz     = '0;
    end else begin
      status = StOk;
    end
  end

  assign sync_pos = pos_e - PosWidth'(3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.take_byte && !found_e) begin
      win_q   <= {win_e[15:0], data_byte_i};
      fill_q  <= (fill_e == 2'd3) ? fill_e : fill_e + 2'd1;
      pos_q   <= pos_e + 1'b1;
      found_q <= hdr_ok;
    end else if (cmd_i.take_byte) begin
      found_q <= found_e;
    end
  end

  // working result registers
  logic [1:0]      st_q, ver_q, lay_q, chan_q;
  logic [31:0]     off_q, fc_q;
  logic [8:0]      kbps_q;
  logic [15:0]     hz_q;
  logic            pad_q;
  logic [FsW-1:0]  fs_q;
  logic [22:0]     dur_q;
  logic [PrdW-1:0] prod_q;
  logic [DvsW-1:0] den_q;

  logic            div_done;
  logic [DvdW-1:0] dvd, quo;
  logic [DvsW-1:0] dvs;

  always_comb begin
    case (cmd_i.div_sel)
      SelFs: begin
        dvd = DvdW'(prod_q);
        dvs = DvsW'(hz_q);
      end
      SelFc: begin
        dvd = DvdW'(audio_q);
        dvs = DvsW'(fs_q);
      end
      SelDur: begin
        dvd = {file_len_q, 3'b000};
        dvs = den_q;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  mahs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && hdr_ok) begin
      st_q   <= status;
      off_q  <= 32'(sync_pos);
      ver_q  <= ver;
      lay_q  <= layer;
      kbps_q <= kbps;
      hz_q   <= hz;
      pad_q  <= pad;
      chan_q <= chan;
      fs_q   <= '0;
      fc_q   <= '0;
      dur_q  <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= PrdW'(kbps_q) * PrdW'((ver_q == VerMpeg1) ? MulMpeg1 : MulMpeg2);
      den_q  <= DvsW'(kbps_q) * DvsW'(KbpsToBps);
    end
    if (cmd_i.cap_fs)  fs_q  <= quo[FsW-1:0] + FsW'(pad_q);
    if (cmd_i.cap_fc)  fc_q  <= quo[31:0];
    if (cmd_i.cap_dur) dur_q <= quo[22:0];
    if (cmd_i.out_load) begin
      status_o         <= st_q;
      header_offset_o  <= off_q;
      version_code_o   <= ver_q;
      layer_number_o   <= lay_q;
      bitrate_kbps_o   <= kbps_q;
      sample_rate_hz_o <= hz_q;
      padding_bit_o    <= pad_q;
      channel_mode_o   <= chan_q;
      frame_bytes_o    <= (fs_q > FsW'(FrameMax)) ? FrameMax : fs_q[10:0];
      frame_count_o    <= fc_q;
      duration_s_o     <= dur_q;
    end
  end

  assign sts_o.hit       = hdr_ok;
  assign sts_o.need_calc = hdr_ok && (status == StOk);
  assign sts_o.div_done  = div_done;

endmodule

// ----- rtl/mahs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mahs_ctrl
// sequencer of byte intake, size divisions and result handoff
// ----------------------------------------------------------------------------
module mahs_ctrl import mahs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    Idle   = 8'b0000_0001,
    Mul    = 8'b0000_0010,
    FsGo   = 8'b0000_0100,
    DivFs  = 8'b0000_1000,
    FcGo   = 8'b0001_0000,
    DivFc  = 8'b0010_0000,
    DivDur = 8'b0100_0000,
    Done   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.div_sel = SelFs;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      Idle: begin
        in_stall_o      = 1'b0;
        cmd_o.take_byte = in_valid_i;
        if (in_valid_i && sts_i.hit) state_d = sts_i.need_calc ? Mul : Done;
      end
      Mul: begin
        cmd_o.mul = 1'b1;
        state_d   = FsGo;
      end
      FsGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = DivFs;
      end
      DivFs: begin
        if (sts_i.div_done) begin
          cmd_o.cap_fs = 1'b1;
          state_d      = FcGo;
        end
      end
      FcGo: begin
        cmd_o.div_sel   = SelFc;
        cmd_o.div_start = 1'b1;
        state_d         = DivFc;
      end
      DivFc: begin
        cmd_o.div_sel = SelDur;
        if (sts_i.div_done) begin
          cmd_o.cap_fc    = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = DivDur;
        end
      end
      DivDur: begin
        cmd_o.div_sel = SelDur;
        if (sts_i.div_done) begin
          cmd_o.cap_dur = 1'b1;
          state_d       = Done;
        end
      end
      Done: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == DivFs || state_q == DivFc || state_q == DivDur))
    else $error("divider finished outside a division step");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded but not presented");

  a_hit_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Idle && in_valid_i && sts_i.hit) |=> state_q != Idle)
    else $error("header found but sequencer stayed idle");

endmodule

// ----- test/tb_mpeg_audio_header_scanner.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mpeg_audio_header_scanner
// self-checking bench: a directed table of byte streams, then random segments
// built around headers, all checked field by field against a local predictor
// ----------------------------------------------------------------------------
module tb_mpeg_audio_header_scanner;
  import mahs_pkg::*;

  localparam int          LimitCycles = 400000;
  localparam int          SettleCycles = 150;  // longer than one full division run
  localparam logic [1:0]  CfgSpare2 = 2'd2;    // unused register indexes
  localparam logic [1:0]  CfgSpare3 = 2'd3;

  // bitrate rows: mpeg1 l1, l2, l3, then mpeg2/2.5 l1, l2/l3
  localparam int unsigned BrTab [0:4][0:14] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
  };
  // sample rates by version code; code 1 is reserved
  localparam int unsigned SrTab [0:3][0:2] = '{
    '{11025, 12000, 8000},
    '{0, 0, 0},
    '{22050, 24000, 16000},
    '{44100, 48000, 32000}
  };

  typedef struct {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic        pad;
    logic [1:0]  chan;
    logic [10:0] fbytes;
    logic [31:0] fcount;
    logic [22:0] dur;
  } header_t;

  // directed row: a byte, its restart flag and, where obvious, status and offset
  typedef struct {
    logic [7:0]  data;
    logic        restart;
    bit          typed;
    logic [1:0]  status;
    logic [31:0] offset;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] header_offset_o;
  logic [1:0]  version_code_o;
  logic [1:0]  layer_number_o;
  logic [8:0]  bitrate_kbps_o;
  logic [15:0] sample_rate_hz_o;
  logic        padding_bit_o;
  logic [1:0]  channel_mode_o;
  logic [10:0] frame_bytes_o;
  logic [31:0] frame_count_o;
  logic [22:0] duration_s_o;

  mpeg_audio_header_scanner uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state and register copies
  logic [23:0] win_bytes;
  int          win_fill;
  logic [31:0] byte_pos;
  bit          hdr_found;
  logic [31:0] len_reg;
  logic [31:0] audio_reg;

  header_t     headers_due[$];
  int          fail_count = 0;
  bit          quiet = 1'b0;       // no idling on either side
  int          hold_cycles = 0;    // long receiver hold-off request
  int          stall_left = 0;
  int          cycle_count = 0;
  int          items_sent = 0;

  // advance the scanner by one byte; returns 1 when a header comes out
  function automatic bit scan_byte(input logic [7:0] b, input logic restart,
                                   output header_t h);
    logic [7:0]      b0, b1, b2;
    int unsigned     lb, ri, si, ver, layer, row, kb, hz;
    longint unsigned fs, mult;
    bit              hit;
    hit = 1'b0;
    h = '{default: '0};
    if (restart) begin
      win_bytes = '0;
      win_fill = 0;
      byte_pos = '0;
      hdr_found = 1'b0;
    end
    if (hdr_found) return 1'b0;
    if (win_fill >= 3) begin
      b0 = win_bytes[23:16];
      b1 = win_bytes[15:8];
      b2 = win_bytes[7:0];
      lb = 32'(b1[2:1]);
      ri = 32'(b2[7:4]);
      si = 32'(b2[3:2]);
      if (b0 == 8'hFF && b1 >= 8'hE0 && ri != 15 && lb != 0 && si < 3) begin
        ver = 32'(b1[4:3]);
        layer = 4 - lb;
        row = (ver == 3) ? layer - 1 : ((layer == 1) ? 3 : 4);
        kb = BrTab[row][ri];
        hz = SrTab[ver][si];
        h.offset = byte_pos - 32'd3;
        h.version = 2'(ver);
        h.layer = 2'(layer);
        h.pad = b2[1];
        h.chan = b[7:6];
        if (ri == 0) begin
          // free rate wins over a reserved version
          h.status = StFree;
          kb = 0;
        end else if (ver == 1) begin
          h.status = StRsv;
          kb = 0;
          hz = 0;
        end else begin
          h.status = StOk;
          mult = (ver == 3) ? 144 : 72;
          fs = mult * kb * 1000 / hz + b2[1];
          h.fbytes = (fs > 2047) ? 11'd2047 : fs[10:0];
          h.fcount = 32'(longint'(audio_reg) / fs);
          h.dur = 23'(longint'(len_reg) * 8 / kb / 1000);
        end
        h.kbps = 9'(kb);
        h.hz = 16'(hz);
        hdr_found = 1'b1;
        hit = 1'b1;
      end
    end else begin
      win_fill++;
    end
    win_bytes = {win_bytes[15:0], b};
    byte_pos = byte_pos + 32'd1;
    return hit;
  endfunction

  task automatic chk(input string name, input longint unsigned e,
                     input longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      fail_count++;
    end
  endtask

  // result side: compare accepted results and drive stall
  always @(posedge clk_i) begin : result_check
    header_t e;
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("%0t: timeout", $time);
      $display("tb_mpeg_audio_header_scanner failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (headers_due.size() == 0) begin
        $display("%0t: result with none expected, offset %0d", $time, header_offset_o);
        fail_count++;
      end else begin
        e = headers_due.pop_front();
        chk("status", e.status, status_o);
        chk("header_offset", e.offset, header_offset_o);
        chk("version_code", e.version, version_code_o);
        chk("layer_number", e.layer, layer_number_o);
        chk("bitrate_kbps", e.kbps, bitrate_kbps_o);
        chk("sample_rate_hz", e.hz, sample_rate_hz_o);
        chk("padding_bit", e.pad, padding_bit_o);
        chk("channel_mode", e.chan, channel_mode_o);
        chk("frame_bytes", e.fbytes, frame_bytes_o);
        chk("frame_count", e.fcount, frame_count_o);
        chk("duration_s", e.dur, duration_s_o);
      end
    end
    // long hold-off first, then random stall bursts
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // offer one item, wait for it to be taken, then predict; an optional
  // expected status and offset from the table override the predictor
  task automatic send_byte(input logic [7:0] b, input logic restart,
                           input bit typed = 0, input logic [1:0] st = '0,
                           input logic [31:0] off = '0);
    header_t h;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (scan_byte(b, restart, h)) begin
      if (typed) begin
        h.status = st;
        h.offset = off;
      end
      headers_due.push_back(h);
    end else if (typed) begin
      $display("%0t: predictor found no header where one was due", $time);
      fail_count++;
    end
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CfgFileLength) len_reg = value;
    else if (idx == CfgAudioBytes) audio_reg = value;
  endtask

  task automatic set_regs(input logic [31:0] flen, input logic [31:0] abytes);
    cfg_write(CfgFileLength, flen);
    cfg_write(CfgAudioBytes, abytes);
    cfg_write(CfgSpare2, $urandom);
    cfg_write(CfgSpare3, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // a restart, some junk, a sync pattern with random fields and trailing bytes, or noise
  task automatic send_segment();
    int n;
    if ($urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, 5);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({3'b111, 5'($urandom_range(0, 31))}, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // noise, with the odd restart and plenty of sync bytes
      repeat ($urandom_range(1, 10))
        send_byte(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 255)),
                  $urandom_range(0, 7) == 0);
    end
  endtask

  row_t directed[] = '{
    // mpeg1 layer 3, 128 kbps, 44.1 khz, then bytes that must be ignored
    '{8'hFF, 1, 0, StOk, 0}, '{8'hFB, 0, 0, StOk, 0}, '{8'h90, 0, 0, StOk, 0},
    '{8'h64, 0, 1, StOk, 0}, '{8'hFF, 0, 0, StOk, 0}, '{8'hFB, 0, 0, StOk, 0},
    // mpeg1 layer 1, top bitrate, mono
    '{8'hFF, 1, 0, StOk, 0}, '{8'hFF, 0, 0, StOk, 0}, '{8'hE0, 0, 0, StOk, 0},
    '{8'hC3, 0, 1, StOk, 0},
    // free rate one byte in
    '{8'h00, 1, 0, StOk, 0}, '{8'hFF, 0, 0, StOk, 0}, '{8'hF3, 0, 0, StOk, 0},
    '{8'h00, 0, 0, StOk, 0}, '{8'h00, 0, 1, StFree, 1},
    // reserved version
    '{8'hFF, 1, 0, StOk, 0}, '{8'hEA, 0, 0, StOk, 0}, '{8'h10, 0, 0, StOk, 0},
    '{8'h40, 0, 1, StRsv, 0},
    // reserved version with free rate reports free rate
    '{8'hFF, 1, 0, StOk, 0}, '{8'hEA, 0, 0, StOk, 0}, '{8'h00, 0, 0, StOk, 0},
    '{8'hFF, 0, 1, StFree, 0},
    // layer bits zero rejected, then an oversized mpeg2.5 layer 1 frame
    '{8'hFF, 1, 0, StOk, 0}, '{8'hE0, 0, 0, StOk, 0}, '{8'hFC, 0, 0, StOk, 0},
    '{8'h0C, 0, 0, StOk, 0}, '{8'hFF, 0, 0, StOk, 0}, '{8'hE6, 0, 0, StOk, 0},
    '{8'hEA, 0, 0, StOk, 0}, '{8'h80, 0, 1, StOk, 4}
  };

  initial begin : stimulus
    logic [31:0] flen, abytes;
    win_bytes = '0;
    win_fill = 0;
    byte_pos = '0;
    hdr_found = 1'b0;
    len_reg = '0;
    audio_reg = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the register extremes
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (directed[i])
      send_byte(directed[i].data, directed[i].restart, directed[i].typed,
                directed[i].status, directed[i].offset);
    drain();

    // random phases, each with its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin flen = '0; abytes = '0; end
        1: begin flen = $urandom; abytes = $urandom; end
        2: begin flen = $urandom_range(0, 5000); abytes = $urandom_range(0, 5000); end
        3: begin flen = 32'hFFFF_FFFF; abytes = 32'hFFFF_FFFF; end
        default: begin flen = $urandom; abytes = $urandom_range(0, 1 << 20); end
      endcase
      set_regs(flen, abytes);
      if (phase == 2) begin
        // receiver holds off while headers keep coming, so the input backs up
        hold_cycles = 600;
        repeat (6) begin
          send_byte(8'hFF, 1'b1);
          send_byte(8'hFB, 1'b0);
          send_byte(8'h90, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      quiet = (phase == 4);
      items_sent = 0;
      while (items_sent < 145) send_segment();
      drain();
    end

    if (fail_count == 0)
      $display("tb_mpeg_audio_header_scanner passed");
    else
      $display("tb_mpeg_audio_header_scanner failed");
    $finish;
  end

endmodule

// ----- mpeg_audio_header_scanner.f -----
rtl/mahs_pkg.sv
rtl/mahs_div.sv
rtl/mahs_datapath.sv
rtl/mahs_ctrl.sv
rtl/mpeg_audio_header_scanner.sv
test/tb_mpeg_audio_header_scanner.sv
